[rtl/core/lens_undistort_remap_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef LENS_UNDISTORT_REMAP_CORE_ASSERT_SVH
`define LENS_UNDISTORT_REMAP_CORE_ASSERT_SVH

// same-cycle implication
`define LUR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LUR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lur_pkg.sv]
// ---------------------------------------------------------------------------
// lur_pkg
// Types, constants and helpers of the lens undistortion remap core.
// ---------------------------------------------------------------------------
`default_nettype none

package lur_pkg;

    localparam int DEF_IMAGE_WIDTH  = 512;
    localparam int DEF_IMAGE_HEIGHT = 512;

    localparam int FRAC       = 28;
    localparam int PIX_FRAC   = 12;
    localparam int Q_W        = 32;
    localparam int FX_W       = 24;
    localparam int COORD_W    = 9;
    localparam int PIX_W      = 8;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int UD_W       = 30;

    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int WARP_LAT  = 11;

    typedef logic signed [Q_W-1:0] t_q;
    typedef logic [FX_W-1:0]       t_fx;
    typedef logic signed [63:0]    t_wide;

    localparam t_q    Q_MAX  = 32'sh7fff_ffff;
    localparam t_q    Q_MIN  = 32'sh8000_0000;
    localparam t_wide Q_ONE  = 64'sd1 <<< FRAC;

    typedef enum logic {
        FN_WRITE = 1'b0,
        FN_READ  = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        REG_K1,
        REG_K2,
        REG_P1,
        REG_P2,
        REG_FX,
        REG_FY,
        REG_CX,
        REG_CY
    } t_reg_idx;

    typedef struct packed {
        t_q  k1;
        t_q  k2;
        t_q  p1;
        t_q  p2;
        t_fx fx;
        t_fx fy;
        t_fx cx;
        t_fx cy;
    } t_cfg;

    localparam t_q  RST_K1 = -32'sd76076785;
    localparam t_q  RST_K2 = 32'sd19853237;
    localparam t_q  RST_P1 = 32'sd51966;
    localparam t_q  RST_P2 = 32'sd4729;
    localparam t_fx RST_FX = 24'd1878647;
    localparam t_fx RST_FY = 24'd1873084;
    localparam t_fx RST_CX = 24'd1504113;
    localparam t_fx RST_CY = 24'd1017344;

    function automatic t_q sat32(input t_wide v);
        if (v > 64'sd2147483647) begin
            return Q_MAX;
        end else if (v < -64'sd2147483648) begin
            return Q_MIN;
        end
        return v[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/lur_if.sv]
// ---------------------------------------------------------------------------
// lur_if
// Request and result channels with valid/ready transfer.
// ---------------------------------------------------------------------------
`default_nettype none

interface lur_req_if import lur_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               func;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pixel_in;

    modport source (output valid, func, col, row, pixel_in, input ready);
    modport sink   (input valid, func, col, row, pixel_in, output ready);
endinterface

interface lur_res_if import lur_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             inside_res;

    modport source (output valid, pixel_out, inside_res, input ready);
    modport sink   (input valid, pixel_out, inside_res, output ready);
endinterface

`default_nettype wire

[rtl/core/lur_ram.sv]
// ---------------------------------------------------------------------------
// lur_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module lur_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/lur_cfg.sv]
// ---------------------------------------------------------------------------
// lur_cfg
// APB register bank holding the lens coefficients and camera intrinsics.
// ---------------------------------------------------------------------------
`default_nettype none

module lur_cfg import lur_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k1 <= RST_K1;
            r_cfg.k2 <= RST_K2;
            r_cfg.p1 <= RST_P1;
            r_cfg.p2 <= RST_P2;
            r_cfg.fx <= RST_FX;
            r_cfg.fy <= RST_FY;
            r_cfg.cx <= RST_CX;
            r_cfg.cy <= RST_CY;
        end else if (wr) begin
            case (idx)
                REG_K1:  r_cfg.k1 <= pwdata;
                REG_K2:  r_cfg.k2 <= pwdata;
                REG_P1:  r_cfg.p1 <= pwdata;
                REG_P2:  r_cfg.p2 <= pwdata;
                REG_FX:  r_cfg.fx <= pwdata[FX_W-1:0];
                REG_FY:  r_cfg.fy <= pwdata[FX_W-1:0];
                REG_CX:  r_cfg.cx <= pwdata[FX_W-1:0];
                REG_CY:  r_cfg.cy <= pwdata[FX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_K1:  prdata = r_cfg.k1;
            REG_K2:  prdata = r_cfg.k2;
            REG_P1:  prdata = r_cfg.p1;
            REG_P2:  prdata = r_cfg.p2;
            REG_FX:  prdata = CFG_DATA_W'(r_cfg.fx);
            REG_FY:  prdata = CFG_DATA_W'(r_cfg.fy);
            REG_CX:  prdata = CFG_DATA_W'(r_cfg.cx);
            REG_CY:  prdata = CFG_DATA_W'(r_cfg.cy);
            default: prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/lur_div.sv]
// ---------------------------------------------------------------------------
// lur_div
// Pipelined normalizer: ((pix*4096 - centre) << 28) / focal, one quotient
// bit per stage, saturated to Q4.28 and truncated toward zero.
// ---------------------------------------------------------------------------
`default_nettype none

module lur_div import lur_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [COORD_W-1:0] i_pix,
    input  t_fx                i_centre,
    input  t_fx                i_focal,
    output t_q                 o_q
);

    localparam int NUM_W  = COORD_W + PIX_FRAC + 5;
    localparam int MAG_W  = FX_W + 1;
    localparam int REM_W  = MAG_W + FRAC;
    localparam int CMP_W  = FX_W + DIV_STEPS;
    localparam int OVF_SH = DIV_STEPS - FRAC;
    localparam int OVF_W  = FX_W + OVF_SH;

    logic signed [NUM_W-1:0] num;
    logic [MAG_W-1:0]        mag;
    logic                    ovf;
    logic [DIV_STEPS-1:0]    q_fin;

    logic [REM_W-1:0]     r_rem [DIV_STEPS+1];
    t_fx                  r_den [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] r_q   [DIV_STEPS+1];
    logic                 r_neg [DIV_STEPS+1];
    logic                 r_ovf [DIV_STEPS+1];
    t_q                   r_out;

    assign num = $signed({5'b0, i_pix, {PIX_FRAC{1'b0}}}) - $signed({2'b0, i_centre});
    assign mag = num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    assign ovf = (mag != '0) && (OVF_W'(mag) >= {i_focal, {OVF_SH{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {mag, {FRAC{1'b0}}};
            r_den[0] <= i_focal;
            r_q[0]   <= '0;
            r_neg[0] <= num[NUM_W-1];
            r_ovf[0] <= ovf;
        end
    end

    for (genvar s = 1; s <= DIV_STEPS; s++) begin : g_step
        localparam int B = DIV_STEPS - s;
        logic [CMP_W-1:0] dsh;
        logic [CMP_W-1:0] diff;
        logic             take;

        assign dsh  = CMP_W'(r_den[s-1]) << B;
        assign take = (r_den[s-1] != '0) && (CMP_W'(r_rem[s-1]) >= dsh);
        assign diff = CMP_W'(r_rem[s-1]) - dsh;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= take ? REM_W'(diff) : r_rem[s-1];
                r_den[s] <= r_den[s-1];
                r_q[s]   <= {r_q[s-1][DIV_STEPS-2:0], take};
                r_neg[s] <= r_neg[s-1];
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign q_fin = r_q[DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[DIV_STEPS]) begin
                r_out <= r_neg[DIV_STEPS] ? Q_MIN : Q_MAX;
            end else if (!r_neg[DIV_STEPS]) begin
                r_out <= q_fin[DIV_STEPS-1] ? Q_MAX : t_q'(q_fin);
            end else begin
                r_out <= (q_fin > DIV_STEPS'(Q_MIN)) ? Q_MIN : t_q'(-q_fin);
            end
        end
    end

    assign o_q = r_out;

endmodule

`default_nettype wire

[rtl/core/lur_warp.sv]
// ---------------------------------------------------------------------------
// lur_warp
// Distortion pipeline: radial and tangential terms, back-projection to
// source pixel coordinates, frame bounds check and frame store address.
// ---------------------------------------------------------------------------
`default_nettype none

module lur_warp import lur_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic                                       i_clk,
    input  logic                                       i_en,
    input  t_cfg                                       i_cfg,
    input  t_q                                         i_x,
    input  t_q                                         i_y,
    output logic                                       o_inside,
    output logic [$clog2(IMAGE_WIDTH*IMAGE_HEIGHT)-1:0] o_addr
);

    localparam int COL_W  = $clog2(IMAGE_WIDTH);
    localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
    localparam int ADDR_W = $clog2(IMAGE_WIDTH*IMAGE_HEIGHT);
    localparam logic signed [UD_W-1:0] X_LIM = UD_W'(IMAGE_WIDTH * (2 ** PIX_FRAC));
    localparam logic signed [UD_W-1:0] Y_LIM = UD_W'(IMAGE_HEIGHT * (2 ** PIX_FRAC));

    logic [63:0] sq;

    t_q    r1_x, r1_y;
    t_wide r1_xx, r1_yy, r1_xy;
    t_q    r2_x, r2_y, r2_x2, r2_y2, r2_xy, r2_r2;
    t_q    r3_x, r3_y, r3_xy, r3_r2, r3_rx, r3_ry;
    t_wide r3_r4p;
    t_q    r4_x, r4_y, r4_xy, r4_r2, r4_rx, r4_ry, r4_r4;
    t_q    r5_x, r5_y, r5_xy, r5_rx, r5_ry;
    t_wide r5_m1, r5_m2;
    t_q    r6_x, r6_y, r6_xy, r6_rx, r6_ry, r6_f;
    t_wide r7_xf, r7_yf, r7_a, r7_b, r7_c, r7_d;
    t_q    r8_xd, r8_yd;
    t_wide r9_pu, r9_pv;
    logic signed [UD_W-1:0] r10_ud, r10_vd;
    logic                   r11_inside;
    logic [ADDR_W-1:0]      r11_addr;

    assign sq = $unsigned(r1_xx) + $unsigned(r1_yy);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x  <= i_x;
            r1_y  <= i_y;
            r1_xx <= t_wide'(i_x) * t_wide'(i_x);
            r1_yy <= t_wide'(i_y) * t_wide'(i_y);
            r1_xy <= t_wide'(i_x) * t_wide'(i_y);

            r2_x  <= r1_x;
            r2_y  <= r1_y;
            r2_x2 <= sat32(r1_xx >>> FRAC);
            r2_y2 <= sat32(r1_yy >>> FRAC);
            r2_xy <= sat32(r1_xy >>> FRAC);
            r2_r2 <= sat32(t_wide'(sq >> FRAC));

            r3_x   <= r2_x;
            r3_y   <= r2_y;
            r3_xy  <= r2_xy;
            r3_r2  <= r2_r2;
            r3_r4p <= t_wide'(r2_r2) * t_wide'(r2_r2);
            r3_rx  <= sat32(t_wide'(r2_r2) + (t_wide'(r2_x2) <<< 1));
            r3_ry  <= sat32(t_wide'(r2_r2) + (t_wide'(r2_y2) <<< 1));

            r4_x  <= r3_x;
            r4_y  <= r3_y;
            r4_xy <= r3_xy;
            r4_r2 <= r3_r2;
            r4_rx <= r3_rx;
            r4_ry <= r3_ry;
            r4_r4 <= sat32(r3_r4p >>> FRAC);

            r5_x  <= r4_x;
            r5_y  <= r4_y;
            r5_xy <= r4_xy;
            r5_rx <= r4_rx;
            r5_ry <= r4_ry;
            r5_m1 <= t_wide'(i_cfg.k1) * t_wide'(r4_r2);
            r5_m2 <= t_wide'(i_cfg.k2) * t_wide'(r4_r4);

            r6_x  <= r5_x;
            r6_y  <= r5_y;
            r6_xy <= r5_xy;
            r6_rx <= r5_rx;
            r6_ry <= r5_ry;
            r6_f  <= sat32(Q_ONE + (r5_m1 >>> FRAC) + (r5_m2 >>> FRAC));

            r7_xf <= t_wide'(r6_x) * t_wide'(r6_f);
            r7_yf <= t_wide'(r6_y) * t_wide'(r6_f);
            r7_a  <= t_wide'(i_cfg.p1) * t_wide'(r6_xy);
            r7_b  <= t_wide'(i_cfg.p2) * t_wide'(r6_xy);
            r7_c  <= t_wide'(i_cfg.p2) * t_wide'(r6_rx);
            r7_d  <= t_wide'(i_cfg.p1) * t_wide'(r6_ry);

            r8_xd <= sat32((r7_xf >>> FRAC) + (r7_a >>> (FRAC - 1)) + (r7_c >>> FRAC));
            r8_yd <= sat32((r7_yf >>> FRAC) + (r7_b >>> (FRAC - 1)) + (r7_d >>> FRAC));

            r9_pu <= t_wide'(i_cfg.fx) * t_wide'(r8_xd);
            r9_pv <= t_wide'(i_cfg.fy) * t_wide'(r8_yd);

            r10_ud <= UD_W'((r9_pu >>> FRAC) + t_wide'(i_cfg.cx));
            r10_vd <= UD_W'((r9_pv >>> FRAC) + t_wide'(i_cfg.cy));

            r11_inside <= !r10_ud[UD_W-1] && !r10_vd[UD_W-1]
                          && (r10_ud < X_LIM) && (r10_vd < Y_LIM);
            r11_addr   <= ADDR_W'(r10_vd[PIX_FRAC +: ROW_W]) * ADDR_W'(IMAGE_WIDTH)
                          + ADDR_W'(r10_ud[PIX_FRAC +: COL_W]);
        end
    end

    assign o_inside = r11_inside;
    assign o_addr   = r11_addr;

endmodule

`default_nettype wire

[rtl/core/lens_undistort_remap_core.sv]
// ---------------------------------------------------------------------------
// lens_undistort_remap_core
// Frame store with radial/tangential lens undistortion remap on read.
// ---------------------------------------------------------------------------
// One item is taken per clock while the result side keeps up. A read request
// gives its result after passing the bit-per-stage pipelined divider that
// normalizes the pixel, the multiplier chain of the distortion model and
// the frame store read. Writes travel the same pipeline and land in the
// frame store in order with the requests, so a request always sees every
// write taken before it. The frame store has one write and one read port
// and needs no clearing after reset.
`default_nettype none

module lens_undistort_remap_core import lur_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lur_req_if.sink               i_req,
    lur_res_if.source             o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

`include "lens_undistort_remap_core_assert.svh"

    localparam int LAT    = DIV_LAT + WARP_LAT;
    localparam int ADDR_W = $clog2(IMAGE_WIDTH*IMAGE_HEIGHT);

    t_cfg              cfg;
    logic              en;
    logic              acc;
    t_q                div_x, div_y;
    logic              w_inside;
    logic [ADDR_W-1:0] w_raddr;
    logic [ADDR_W-1:0] in_addr;
    logic              in_wok;
    logic              ram_we, ram_re;
    logic [PIX_W-1:0]  ram_rdata;

    logic [LAT-1:0]    r_vld;
    logic              r_fn    [LAT];
    logic              r_wok   [LAT];
    logic [ADDR_W-1:0] r_waddr [LAT];
    logic [PIX_W-1:0]  r_wpix  [LAT];
    logic              r_out_vld;
    logic              r_out_inside;

    lur_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign en          = !r_out_vld || o_res.ready;
    assign i_req.ready = en;
    assign acc         = i_req.valid && en;

    assign in_wok  = (int'(i_req.col) < IMAGE_WIDTH) && (int'(i_req.row) < IMAGE_HEIGHT);
    assign in_addr = ADDR_W'(i_req.row) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(i_req.col);

    lur_div u_div_x (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pix    (i_req.col),
        .i_centre (cfg.cx),
        .i_focal  (cfg.fx),
        .o_q      (div_x)
    );

    lur_div u_div_y (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_pix    (i_req.row),
        .i_centre (cfg.cy),
        .i_focal  (cfg.fy),
        .o_q      (div_y)
    );

    lur_warp #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_warp (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_cfg    (cfg),
        .i_x      (div_x),
        .i_y      (div_y),
        .o_inside (w_inside),
        .o_addr   (w_raddr)
    );

    // advance the item tags alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], acc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fn[0]    <= i_req.func;
            r_wok[0]   <= in_wok;
            r_waddr[0] <= in_addr;
            r_wpix[0]  <= i_req.pixel_in;
            for (int i = 1; i < LAT; i++) begin
                r_fn[i]    <= r_fn[i-1];
                r_wok[i]   <= r_wok[i-1];
                r_waddr[i] <= r_waddr[i-1];
                r_wpix[i]  <= r_wpix[i-1];
            end
        end
    end

    assign ram_we = en && r_vld[LAT-1] && (r_fn[LAT-1] == FN_WRITE) && r_wok[LAT-1];
    assign ram_re = en && r_vld[LAT-1] && (r_fn[LAT-1] == FN_READ) && w_inside;

    lur_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (IMAGE_WIDTH*IMAGE_HEIGHT)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_waddr[LAT-1]),
        .i_wdata (r_wpix[LAT-1]),
        .i_re    (ram_re),
        .i_raddr (w_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[LAT-1] && (r_fn[LAT-1] == FN_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_inside <= w_inside;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.inside_res = r_out_inside;
    assign o_res.pixel_out  = r_out_inside ? ram_rdata : '0;

    `LUR_ASSERT_NEXT(a_stall_hold, o_res.valid && !o_res.ready, $stable(r_vld), "pipeline moved while stalled")
    `LUR_ASSERT_NEXT(a_read_result, en && r_vld[LAT-1] && (r_fn[LAT-1] == FN_READ), o_res.valid, "request lost before output")
    `LUR_ASSERT_NOW(a_port_excl, ram_we, !ram_re, "frame store read and write in one cycle")

endmodule

`default_nettype wire
